FILE: rtl/crt_pkg.sv
// shared types and codes for the credit limited request tracker
`default_nettype none

package crt_pkg;

    localparam int ID_W     = 64;
    localparam int MODE_W   = 2;
    localparam int ORIGIN_W = 2;
    localparam int STATUS_W = 3;
    localparam int LIMIT_W  = 5;
    localparam int CFG_IDX_W = 2;

    // packed stream widths, padded to whole bytes
    localparam int IN_FIELDS_W  = MODE_W + ORIGIN_W + ID_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + 1 + ID_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_SUBMIT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPLETE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CLOSED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOBBY_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAIN_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_CLOSED = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd8;

    // priority chain passed from cell to cell, lowest slot first
    typedef struct packed {
        logic free_seen;
        logic hit_seen;
    } crt_chain_t;

    // per item command broadcast to every cell
    typedef struct packed {
        logic load;
        logic alloc;
        logic clear;
    } crt_cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/crt_cell.sv
// one credit slot cell: holds a slot and takes part in the lowest-first chain
`default_nettype none

module crt_cell
    import crt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire crt_cell_cmd_t       cmd,
    input  wire logic                load_origin,
    input  wire logic [ID_W-1:0]     load_id,
    input  wire logic                wr_origin,
    input  wire logic [ID_W-1:0]     wr_id,
    input  wire crt_chain_t          chain_in,
    output crt_chain_t               chain_out
);

    logic            valid_reg;
    logic            origin_reg;
    logic [ID_W-1:0] id_reg;
    logic            hit_reg;
    logic            alloc_here;
    logic            clear_here;

    assign alloc_here = cmd.alloc & ~valid_reg & ~chain_in.free_seen;
    assign clear_here = cmd.clear & hit_reg & ~chain_in.hit_seen;

    assign chain_out.free_seen = chain_in.free_seen | ~valid_reg;
    assign chain_out.hit_seen  = chain_in.hit_seen | hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                hit_reg <= valid_reg && (origin_reg == load_origin) && (id_reg == load_id);
            end
            if (alloc_here)
            begin
                valid_reg <= 1'b1;
            end
            else if (clear_here)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc_here)
        begin
            origin_reg <= wr_origin;
            id_reg     <= wr_id;
        end
        else if (clear_here)
        begin
            origin_reg <= 1'b0;
            id_reg     <= '0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/crt_queue.sv
// arrival order queue of admitted requests, origin and id per entry
`default_nettype none

module crt_queue
    import crt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    input  wire logic                                 pop,
    input  wire logic                                 push_origin,
    input  wire logic [ID_W-1:0]                      push_id,
    output logic                                      head_origin,
    output logic [ID_W-1:0]                           head_id,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]          count
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    logic [ID_W:0]      mem [QUEUE_DEPTH];
    logic [ID_W:0]      rd_data_reg;
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   tail_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   head_next;
    logic [PTR_W-1:0]   tail_next;
    logic [CNT_W-1:0]   count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next  = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        if (pop)
        begin
            head_next  = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // head entry read every cycle, registered
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= {push_id, push_origin};
        end
        rd_data_reg <= mem[head_reg];
    end

    assign head_origin = rd_data_reg[0];
    assign head_id     = rd_data_reg[ID_W:1];
    assign count       = count_reg;

endmodule

`default_nettype wire

FILE: rtl/credit_limited_request_tracker.sv
// top level of the credit limited request tracker
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+---------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | mode, origin, req_id
//  m_*     | out | m_tvalid/m_tready  | status, out_origin, out_req_id
//  cfg_*   | in  | cfg_we             | lobby_limit, main_limit, queue_closed
//
//  for each request the accept edge captures it and every cell compares it
//  with its slot, then the commit edge applies the decision taken along the
//  cell chain and loads the result register
//  a request that finds the result register still full waits in evaluation
//  until the downstream side takes the previous result
//  reset clears all slots, counts and queue pointers; limits reset to 8
`default_nettype none

module credit_limited_request_tracker
    import crt_pkg::*;
#(
    parameter int CREDIT_SLOTS = 16,
    parameter int QUEUE_DEPTH  = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // request stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // mode[1:0], origin[3:2], req_id[67:4]
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // status[2:0], out_origin[3], out_req_id[67:4]
    // configuration writes
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [LIMIT_W-1:0]     cfg_wdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] QUEUE_FULL_CNT = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [LIMIT_W-1:0] lobby_limit_reg;
    logic [LIMIT_W-1:0] main_limit_reg;
    logic               queue_closed_reg;

    // class counts
    logic [LIMIT_W-1:0] lobby_count_reg, lobby_count_next;
    logic [LIMIT_W-1:0] main_count_reg, main_count_next;

    // captured request
    logic [MODE_W-1:0]   mode_reg;
    logic [ORIGIN_W-1:0] origin_reg;
    logic [ID_W-1:0]     id_reg;

    // result register
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;

    logic                s_xfer;
    logic                commit;
    logic                bad_args;
    logic                sel_lobby;
    logic [LIMIT_W-1:0]  sel_limit;
    logic [LIMIT_W-1:0]  sel_count;
    logic                any_free;
    logic                any_hit;

    logic [STATUS_W-1:0] status;
    logic                out_origin;
    logic [ID_W-1:0]     out_id;
    logic                do_alloc;
    logic                do_clear;
    logic                do_pop;
    logic                count_inc;
    logic                count_dec;

    // queue
    logic               q_head_origin;
    logic [ID_W-1:0]    q_head_id;
    logic [CNT_W-1:0]   q_count;

    // cell chain
    crt_cell_cmd_t      cell_cmd;
    crt_chain_t         chain [CREDIT_SLOTS+1];

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid & s_tready;
    assign commit   = (state_reg == S_EVAL) & (~m_tvalid_reg | m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lobby_limit_reg  <= LIMIT_RESET;
            main_limit_reg   <= LIMIT_RESET;
            queue_closed_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_LOBBY_LIMIT:  lobby_limit_reg  <= cfg_wdata;
                REG_MAIN_LIMIT:   main_limit_reg   <= cfg_wdata;
                REG_QUEUE_CLOSED: queue_closed_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // request capture, payload only
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            mode_reg   <= s_tdata[MODE_W-1:0];
            origin_reg <= s_tdata[MODE_W +: ORIGIN_W];
            id_reg     <= s_tdata[MODE_W+ORIGIN_W +: ID_W];
        end
    end

    // slot cells, lowest index sees the chain first
    assign cell_cmd.load  = s_xfer;
    assign cell_cmd.alloc = commit & do_alloc;
    assign cell_cmd.clear = commit & do_clear;
    assign chain[0]       = '0;

    for (genvar i = 0; i < CREDIT_SLOTS; i++)
    begin : g_cell
        crt_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cell_cmd),
            .load_origin (s_tdata[MODE_W]),
            .load_id     (s_tdata[MODE_W+ORIGIN_W +: ID_W]),
            .wr_origin   (origin_reg[0]),
            .wr_id       (id_reg),
            .chain_in    (chain[i]),
            .chain_out   (chain[i+1])
        );
    end

    assign any_free = chain[CREDIT_SLOTS].free_seen;
    assign any_hit  = chain[CREDIT_SLOTS].hit_seen;

    crt_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (commit & do_alloc),
        .pop         (commit & do_pop),
        .push_origin (origin_reg[0]),
        .push_id     (id_reg),
        .head_origin (q_head_origin),
        .head_id     (q_head_id),
        .count       (q_count)
    );

    // decision for the captured request
    assign bad_args  = (id_reg == '0) | origin_reg[1];
    assign sel_lobby = ~origin_reg[0];
    assign sel_limit = sel_lobby ? lobby_limit_reg : main_limit_reg;
    assign sel_count = sel_lobby ? lobby_count_reg : main_count_reg;

    always_comb
    begin
        status     = ST_INVALID;
        out_origin = 1'b0;
        out_id     = '0;
        do_alloc   = 1'b0;
        do_clear   = 1'b0;
        do_pop     = 1'b0;
        count_inc  = 1'b0;
        count_dec  = 1'b0;
        case (mode_reg)
            MODE_SUBMIT:
            begin
                if (bad_args || (sel_limit == '0) || any_hit)
                begin
                    status = ST_INVALID;
                end
                else if (queue_closed_reg)
                begin
                    status = ST_CLOSED;
                end
                else if ((sel_count >= sel_limit) || (q_count == QUEUE_FULL_CNT) || !any_free)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status    = ST_OK;
                    do_alloc  = 1'b1;
                    count_inc = 1'b1;
                end
            end
            MODE_POP:
            begin
                if (q_count == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    status     = ST_OK;
                    out_origin = q_head_origin;
                    out_id     = q_head_id;
                    do_pop     = 1'b1;
                end
            end
            MODE_COMPLETE:
            begin
                if (!bad_args && any_hit)
                begin
                    // slot is freed even when the class count is already zero
                    do_clear = 1'b1;
                    if (sel_count != '0)
                    begin
                        status    = ST_OK;
                        count_dec = 1'b1;
                    end
                end
            end
            default:
            begin
                status = ST_INVALID;
            end
        endcase
    end

    // class counts
    always_comb
    begin
        lobby_count_next = lobby_count_reg;
        main_count_next  = main_count_reg;
        if (commit && count_inc)
        begin
            if (sel_lobby)
                lobby_count_next = lobby_count_reg + 1'b1;
            else
                main_count_next  = main_count_reg + 1'b1;
        end
        else if (commit && count_dec)
        begin
            if (sel_lobby)
                lobby_count_next = lobby_count_reg - 1'b1;
            else
                main_count_next  = main_count_reg - 1'b1;
        end
    end

    // control state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_xfer) state_next = S_EVAL;
            S_EVAL:  if (commit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign m_tvalid_next = commit | (m_tvalid_reg & ~m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            lobby_count_reg <= '0;
            main_count_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            lobby_count_reg <= lobby_count_next;
            main_count_reg  <= main_count_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            m_tdata_reg <= OUT_TDATA_W'({out_id, out_origin, status});
        end
    end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// self-checking testbench for the credit limited request tracker
`timescale 1ns / 1ps

module testbench;
    import crt_pkg::*;

    localparam int SLOTS       = 16;
    localparam int DEPTH       = 16;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 400000;

    // codes the package leaves unnamed
    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [ORIGIN_W-1:0] origin;
        logic [ID_W-1:0]     id;
    } tracker_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                origin;
        logic [ID_W-1:0]     id;
    } tracker_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [LIMIT_W-1:0]     cfg_wdata;

    credit_limited_request_tracker #(
        .CREDIT_SLOTS (SLOTS),
        .QUEUE_DEPTH  (DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // shadow of the tracker: credit slots, class counts, request fifo
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] lobby_cap;
    logic [LIMIT_W-1:0] main_cap;
    logic               queue_shut;

    logic               slot_used [SLOTS];
    logic               slot_org  [SLOTS];
    logic [ID_W-1:0]    slot_tag  [SLOTS];
    logic [LIMIT_W-1:0] lobby_held;
    logic [LIMIT_W-1:0] main_held;
    logic               fifo_org  [DEPTH];
    logic [ID_W-1:0]    fifo_tag  [DEPTH];
    logic [PTR_W-1:0]   fifo_head;
    logic [PTR_W-1:0]   fifo_tail;
    int                 fifo_fill;

    tracker_req_t    req_backlog[$];        // requests waiting for the driver
    tracker_result_t predicted_results[$];  // outcomes of accepted requests, oldest first
    tracker_req_t    live_pairs[$];         // pairs the generator believes are in flight

    tracker_req_t cur_req;
    bit           req_taken;
    int           src_gap;
    int           sink_gap;
    int           idle_pct;
    int           items_queued;
    int           results_seen;
    int           mismatches;
    int           cycle_count;

    // works out the response to one request and advances the shadow state
    function automatic tracker_result_t tracker_outcome(tracker_req_t r);
        tracker_result_t    res;
        logic [LIMIT_W-1:0] cap;
        logic [LIMIT_W-1:0] cnt;
        int                 free_idx;
        int                 hit_idx;
        res        = '0;
        res.status = ST_INVALID;
        free_idx   = -1;
        hit_idx    = -1;
        cap        = r.origin[0] ? main_cap : lobby_cap;
        cnt        = r.origin[0] ? main_held : lobby_held;
        // lowest free slot and lowest slot already holding this pair
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!slot_used[i])
            begin
                if (free_idx < 0)
                    free_idx = i;
            end
            else if (slot_org[i] == r.origin[0] && slot_tag[i] == r.id && hit_idx < 0)
            begin
                hit_idx = i;
            end
        end
        case (r.mode)
            MODE_SUBMIT:
            begin
                // invalid checks come first, then closed, then the capacity checks
                if (r.id == '0 || r.origin > 2'd1 || cap == '0 || hit_idx >= 0)
                    res.status = ST_INVALID;
                else if (queue_shut)
                    res.status = ST_CLOSED;
                else if (cnt >= cap || fifo_fill >= DEPTH || free_idx < 0)
                    res.status = ST_FULL;
                else
                begin
                    slot_used[free_idx] = 1'b1;
                    slot_org[free_idx]  = r.origin[0];
                    slot_tag[free_idx]  = r.id;
                    if (r.origin[0])
                        main_held = main_held + 1'b1;
                    else
                        lobby_held = lobby_held + 1'b1;
                    fifo_org[fifo_tail] = r.origin[0];
                    fifo_tag[fifo_tail] = r.id;
                    fifo_tail = fifo_tail + 1'b1;
                    fifo_fill++;
                    res.status = ST_OK;
                end
            end
            MODE_POP:
            begin
                // a pop never touches the credit slots
                if (fifo_fill == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.origin = fifo_org[fifo_head];
                    res.id     = fifo_tag[fifo_head];
                    res.status = ST_OK;
                    fifo_head  = fifo_head + 1'b1;
                    fifo_fill--;
                end
            end
            MODE_COMPLETE:
            begin
                if (r.id != '0 && r.origin <= 2'd1 && hit_idx >= 0)
                begin
                    // the slot is freed even when the count is already zero
                    slot_used[hit_idx] = 1'b0;
                    slot_org[hit_idx]  = 1'b0;
                    slot_tag[hit_idx]  = '0;
                    if (cnt != '0)
                    begin
                        if (r.origin[0])
                            main_held = main_held - 1'b1;
                        else
                            lobby_held = lobby_held - 1'b1;
                        res.status = ST_OK;
                    end
                end
            end
            default:
            begin
                res.status = ST_INVALID;
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // request side: accept at the rising edge, drive at the falling edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            predicted_results.push_back(tracker_outcome(cur_req));
            req_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        logic next_valid;
        next_valid = s_tvalid && !req_taken;
        req_taken  = 1'b0;
        if (rst_n && !next_valid)
        begin
            // gap bursts land between transfers at random points of the work
            if (src_gap > 0)
                src_gap--;
            else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
                src_gap = $urandom_range(9, 1) - 1;
            else if (req_backlog.size() != 0)
            begin
                cur_req    = req_backlog.pop_front();
                next_valid = 1'b1;
                s_tdata   <= IN_TDATA_W'({cur_req.id, cur_req.origin, cur_req.mode});
            end
        end
        s_tvalid <= next_valid;
    end

    // ------------------------------------------------------------------
    // result side: random stalls, compare each transfer with the oldest prediction
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (sink_gap > 0)
        begin
            sink_gap--;
            m_tready <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            sink_gap  = $urandom_range(9, 1) - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        tracker_result_t want;
        tracker_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tdata[STATUS_W-1:0];
            got.origin = m_tdata[STATUS_W];
            got.id     = m_tdata[STATUS_W+1 +: ID_W];
            results_seen++;
            if (predicted_results.size() == 0)
            begin
                $error("result with no pending request: status %0d", got.status);
                mismatches++;
            end
            else
            begin
                want = predicted_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.origin !== want.origin)
                begin
                    $error("out_origin: expected %0d, actual %0d", want.origin, got.origin);
                    mismatches++;
                end
                if (got.id !== want.id)
                begin
                    $error("out_req_id: expected %h, actual %h", want.id, got.id);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_req(logic [MODE_W-1:0] mode, logic [ORIGIN_W-1:0] origin,
                            logic [ID_W-1:0] id);
        tracker_req_t r;
        r.mode   = mode;
        r.origin = origin;
        r.id     = id;
        req_backlog.push_back(r);
        items_queued++;
    endtask

    // register write, only called while the tracker is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LOBBY_LIMIT:  lobby_cap  = val;
            REG_MAIN_LIMIT:   main_cap   = val;
            REG_QUEUE_CLOSED: queue_shut = val[0];
            default:          ;
        endcase
    endtask

    // sender holds off until every request is sent and every result is back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || s_tvalid || results_seen < items_queued);
        repeat (4) @(negedge clk);
    endtask

    // mostly submit and complete of pairs the generator tracks, with noise
    task automatic queue_random(int count, int submit_pct, int pop_pct);
        tracker_req_t r;
        int           roll;
        int           pick;
        int           idx;
        for (int k = 0; k < count; k++)
        begin
            roll     = $urandom_range(99);
            pick     = $urandom_range(19);
            r.origin = 2'($urandom_range(1));
            r.id     = {$urandom, $urandom};
            if (roll < submit_pct)
            begin
                r.mode = MODE_SUBMIT;
                if (pick == 0)
                    r.id = '0;
                else if (pick == 1)
                    r.origin = 2'($urandom_range(3, 2));
                else if (pick < 4 && live_pairs.size() != 0)
                begin
                    // origin and id each taken from a pair that is probably in flight, not always the same pair
                    r.origin = live_pairs[$urandom_range(live_pairs.size() - 1)].origin;
                    r.id     = live_pairs[$urandom_range(live_pairs.size() - 1)].id;
                end
                else
                begin
                    live_pairs.push_back(r);
                    if (live_pairs.size() > 40)
                        void'(live_pairs.pop_front());
                end
            end
            else if (roll < submit_pct + pop_pct)
            begin
                // origin and id are ignored by a pop, random bits anyway
                r.mode   = MODE_POP;
                r.origin = 2'($urandom_range(3));
            end
            else if (roll < 97)
            begin
                r.mode = MODE_COMPLETE;
                if (pick == 0)
                    r.id = '0;
                else if (pick == 1)
                    r.origin = 2'($urandom_range(3, 2));
                else if (pick > 3 && live_pairs.size() != 0)
                begin
                    idx = $urandom_range(live_pairs.size() - 1);
                    r.origin = live_pairs[idx].origin;
                    r.id     = live_pairs[idx].id;
                    live_pairs.delete(idx);
                end
            end
            else
            begin
                r.mode   = MODE_UNUSED;
                r.origin = 2'($urandom_range(3));
            end
            push_req(r.mode, r.origin, r.id);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        lobby_cap      = LIMIT_RESET;
        main_cap       = LIMIT_RESET;
        queue_shut     = 1'b0;
        lobby_held     = '0;
        main_held      = '0;
        fifo_head      = '0;
        fifo_tail      = '0;
        fifo_fill      = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            slot_org[i]  = 1'b0;
            slot_tag[i]  = '0;
        end
        req_taken    = 1'b0;
        src_gap      = 0;
        sink_gap     = 0;
        idle_pct     = 20;
        items_queued = 0;
        results_seen = 0;
        mismatches   = 0;
        cycle_count  = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes of the id, bad origins, duplicates, every mode
        push_req(MODE_SUBMIT, 2'd0, 64'd1);
        push_req(MODE_SUBMIT, 2'd1, '1);
        push_req(MODE_SUBMIT, 2'd0, '0);
        push_req(MODE_SUBMIT, 2'd2, 64'd5);
        push_req(MODE_SUBMIT, 2'd3, '1);
        push_req(MODE_SUBMIT, 2'd0, 64'd1);      // same pair still in flight
        push_req(MODE_SUBMIT, 2'd1, 64'd1);      // same id, other class
        push_req(MODE_POP, 2'd0, '0);
        push_req(MODE_POP, 2'd3, '1);
        push_req(MODE_POP, 2'd0, '0);
        push_req(MODE_POP, 2'd0, '0);            // fifo drained
        push_req(MODE_COMPLETE, 2'd0, 64'd1);
        push_req(MODE_COMPLETE, 2'd0, 64'd1);    // already freed
        push_req(MODE_COMPLETE, 2'd0, '0);
        push_req(MODE_COMPLETE, 2'd3, '1);
        push_req(MODE_UNUSED, 2'd1, 64'd7);
        push_req(MODE_COMPLETE, 2'd1, '1);
        push_req(MODE_COMPLETE, 2'd1, 64'd1);
        wait_idle();

        // write to a register index that does not exist, then a limit of one
        write_reg(REG_UNUSED, 5'h1f);
        write_reg(REG_LOBBY_LIMIT, 5'd1);
        push_req(MODE_SUBMIT, 2'd0, 64'd2);
        push_req(MODE_SUBMIT, 2'd0, 64'd3);      // class at its limit
        push_req(MODE_COMPLETE, 2'd0, 64'd2);
        push_req(MODE_SUBMIT, 2'd0, 64'd3);
        push_req(MODE_POP, 2'd0, '0);
        push_req(MODE_POP, 2'd0, '0);
        wait_idle();

        // widest limits: slots run out before either class limit
        write_reg(REG_LOBBY_LIMIT, 5'd16);
        write_reg(REG_MAIN_LIMIT, 5'd16);
        queue_random(150, 55, 15);

        // narrow lobby, wide main, frequent pops
        write_reg(REG_LOBBY_LIMIT, 5'd1);
        queue_random(120, 45, 30);

        // narrow main, rare pops so the fifo fills up
        write_reg(REG_LOBBY_LIMIT, 5'd16);
        write_reg(REG_MAIN_LIMIT, 5'd1);
        queue_random(120, 45, 5);

        // queue closed to every submit
        write_reg(REG_MAIN_LIMIT, 5'd8);
        write_reg(REG_QUEUE_CLOSED, 5'd1);
        idle_pct = 0;
        queue_random(40, 50, 20);

        // lobby limit of zero rejects every lobby submit as invalid
        write_reg(REG_QUEUE_CLOSED, 5'd0);
        write_reg(REG_LOBBY_LIMIT, 5'd0);
        idle_pct = 35;
        queue_random(60, 50, 20);

        // random settings and mixes
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_LOBBY_LIMIT, 5'($urandom_range(16, 1)));
            write_reg(REG_MAIN_LIMIT, 5'($urandom_range(16, 1)));
            idle_pct = $urandom_range(2) * 15;
            queue_random(110, $urandom_range(60, 30), $urandom_range(35, 15));
        end

        // last stretch at full rate on both sides
        write_reg(REG_LOBBY_LIMIT, LIMIT_RESET);
        write_reg(REG_MAIN_LIMIT, LIMIT_RESET);
        idle_pct = 0;
        queue_random(120, 45, 25);

        repeat (10) @(negedge clk);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: credit_limited_request_tracker.f
rtl/crt_pkg.sv
rtl/crt_cell.sv
rtl/crt_queue.sv
rtl/credit_limited_request_tracker.sv
sim/testbench.sv
